>>> rtl/core/rcsa_pkg.sv
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and constants for the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

    localparam int SLOTS_DEF      = 256;
    localparam int COUNT_BITS_DEF = 16;
    localparam int MAP_ROW_MAX    = 32;

    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 8;
    localparam int INDEX_W   = 8;
    localparam int REF_W     = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_state_t;

    typedef struct packed {
        logic lookup;
        logic alloc;
        logic update;
        logic set;
    } map_cmd_t;

endpackage

>>> rtl/core/rcsa_slot_map.sv
// ----------------------------------------------------------------------------
// rcsa_slot_map
// In-use bitmap kept in a row memory, with per-row valid and full flags.
// Looks up a row (addressed, or the lowest non-full one) and updates it.
// ----------------------------------------------------------------------------
module rcsa_slot_map #(
    parameter int SLOTS = rcsa_pkg::SLOTS_DEF,
    localparam int SLOT_AW  = $clog2(SLOTS),
    localparam int ROW_W    = (SLOTS < rcsa_pkg::MAP_ROW_MAX) ? (1 << SLOT_AW)
                                                               : rcsa_pkg::MAP_ROW_MAX,
    localparam int ROWS     = (SLOTS + ROW_W - 1) / ROW_W,
    localparam int ROW_BITS = $clog2(ROWS),
    localparam int ROW_AW   = (ROW_BITS > 0) ? ROW_BITS : 1,
    localparam int BIT_AW   = $clog2(ROW_W)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rcsa_pkg::map_cmd_t  cmd,
    input  logic [ROW_AW-1:0]   row_addr,
    input  logic [BIT_AW-1:0]   bit_addr,
    output logic [ROW_AW-1:0]   row_sel,
    output logic [ROW_W-1:0]    row_bits,
    output logic [BIT_AW-1:0]   free_bit,
    output logic                none_free
);
    import rcsa_pkg::*;

    logic [ROW_W-1:0]  bitmap_mem [ROWS];
    logic [ROWS-1:0]   row_valid_reg;
    logic [ROWS-1:0]   row_full_reg;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_valid_reg;
    logic [ROW_AW-1:0] row_sel_reg;
    logic              none_free_reg;

    logic [ROW_AW-1:0] free_row;
    logic [ROW_AW-1:0] look_row;
    logic [ROW_W-1:0]  pad_mask;
    logic [ROW_W-1:0]  row_eff;
    logic [ROW_W-1:0]  row_new;

    always_comb
    begin
        free_row = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!row_full_reg[r])
                free_row = ROW_AW'(r);
        end
    end

    assign look_row = cmd.alloc ? free_row : row_addr;

    // bits past the last slot read as taken
    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
            pad_mask[b] = ((int'(row_sel_reg) * ROW_W) + b) >= SLOTS;
    end

    assign row_eff = (rd_valid_reg ? rd_data_reg : '0) | pad_mask;

    always_comb
    begin
        free_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (!row_eff[b])
                free_bit = BIT_AW'(b);
        end
    end

    always_comb
    begin
        row_new           = row_eff;
        row_new[bit_addr] = cmd.set;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rd_data_reg   <= bitmap_mem[look_row];
            rd_valid_reg  <= row_valid_reg[look_row];
            row_sel_reg   <= look_row;
            none_free_reg <= &row_full_reg;
        end
        if (cmd.update)
            bitmap_mem[row_sel_reg] <= row_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            row_full_reg  <= '0;
        end
        else if (cmd.update)
        begin
            row_valid_reg[row_sel_reg] <= 1'b1;
            row_full_reg[row_sel_reg]  <= &row_new;
        end
    end

    assign row_sel   = row_sel_reg;
    assign row_bits  = row_eff;
    assign none_free = none_free_reg;

endmodule

>>> rtl/core/refcounted_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// refcounted_slot_allocator_core
// Reference-counted slot table: allocate lowest free slot, acquire, release.
// ----------------------------------------------------------------------------
// Order: a word is accepted in S_IDLE, where the memories are read; it executes in S_EXEC
// once the output register is free (read step, then modify/write-back step on the count
// memory and the in-use bitmap memory). No new word is taken while in S_EXEC.
// Reset: all slots free at once through per-row valid flags; no clearing pass.
// One more word is taken while a result waits; then input stalls until it is read.
module refcounted_slot_allocator_core #(
    parameter int SLOTS      = rcsa_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = rcsa_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // handle_valid[0], slot_handle[8:1], auto_release[9], zero pad
    input  logic [rcsa_pkg::S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [rcsa_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_index[7:0], ref_count[23:8], slot_freed[24], zero pad
    output logic [rcsa_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]                     m_tuser
);
    import rcsa_pkg::*;

    localparam int SLOT_AW  = $clog2(SLOTS);
    localparam int ROW_W    = (SLOTS < MAP_ROW_MAX) ? (1 << SLOT_AW) : MAP_ROW_MAX;
    localparam int ROWS     = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_BITS = $clog2(ROWS);
    localparam int ROW_AW   = (ROW_BITS > 0) ? ROW_BITS : 1;
    localparam int BIT_AW   = $clog2(ROW_W);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // input fields
    op_t                 op_in;
    logic                hv_in;
    logic [HANDLE_W-1:0] handle_in;
    logic                ar_in;
    logic                h_range;
    logic                bad_in;
    logic [SLOT_AW-1:0]  h_addr;
    logic [ROW_AW-1:0]   h_row;
    logic                accept;
    logic                exec_go;

    fsm_state_t          state_reg, state_next;
    op_t                 op_reg;
    logic                ar_reg;
    logic                bad_reg;
    logic [BIT_AW-1:0]   bit_reg;
    logic [SLOT_AW-1:0]  addr_reg;

    logic [COUNT_BITS:0] cnt_mem [SLOTS];
    logic [COUNT_BITS:0] cnt_rd_reg;
    logic                cnt_we;
    logic [SLOT_AW-1:0]  cnt_waddr;
    logic [COUNT_BITS:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                auto_cur;

    map_cmd_t            map_cmd;
    logic [BIT_AW-1:0]   map_bit;
    logic [ROW_AW-1:0]   map_row_sel;
    logic [ROW_W-1:0]    map_bits;
    logic [BIT_AW-1:0]   map_free_bit;
    logic                map_none_free;
    logic [SLOT_AW-1:0]  alloc_slot;
    logic                in_use_bit;

    status_t             res_status;
    logic [INDEX_W-1:0]  res_index;
    logic [REF_W-1:0]    res_count;
    logic                res_freed;

    logic                m_tvalid_reg, m_tvalid_next;
    status_t             status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [REF_W-1:0]    count_reg;
    logic                freed_reg;

    assign op_in     = op_t'(s_tuser);
    assign hv_in     = s_tdata[0];
    assign handle_in = s_tdata[8:1];
    assign ar_in     = s_tdata[9];
    assign h_range   = int'(handle_in) < SLOTS;
    assign h_addr    = h_range ? SLOT_AW'(handle_in) : '0;
    assign h_row     = ROW_AW'(h_addr >> BIT_AW);
    assign bad_in    = !((op_in == OP_ACQUIRE) || (op_in == OP_RELEASE)) || !hv_in
                       || !h_range;

    assign accept  = s_tvalid && s_tready;
    assign exec_go = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    rcsa_slot_map #(
        .SLOTS (SLOTS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (map_cmd),
        .row_addr  (h_row),
        .bit_addr  (map_bit),
        .row_sel   (map_row_sel),
        .row_bits  (map_bits),
        .free_bit  (map_free_bit),
        .none_free (map_none_free)
    );

    assign alloc_slot = SLOT_AW'({map_row_sel, map_free_bit});
    assign in_use_bit = map_bits[bit_reg];
    assign cnt_cur    = cnt_rd_reg[COUNT_BITS-1:0];
    assign auto_cur   = cnt_rd_reg[COUNT_BITS];
    assign cnt_inc    = (cnt_cur != CNT_MAX) ? cnt_cur + COUNT_BITS'(1) : cnt_cur;
    assign cnt_dec    = (cnt_cur != '0) ? cnt_cur - COUNT_BITS'(1) : cnt_cur;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        map_cmd    = '0;
        map_bit    = bit_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = addr_reg;
        cnt_wdata  = '0;
        res_status = ST_BAD;
        res_index  = '0;
        res_count  = '0;
        res_freed  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready       = 1'b1;
                map_cmd.lookup = s_tvalid;
                map_cmd.alloc  = (op_in == OP_ALLOC);
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if (map_none_free)
                                res_status = ST_FULL;
                            else
                            begin
                                res_status     = ST_OK;
                                res_index      = INDEX_W'(alloc_slot);
                                res_count      = REF_W'(1);
                                map_cmd.update = 1'b1;
                                map_cmd.set    = 1'b1;
                                map_bit        = map_free_bit;
                                cnt_we         = 1'b1;
                                cnt_waddr      = alloc_slot;
                                cnt_wdata      = {ar_reg, COUNT_BITS'(1)};
                            end
                        end
                        OP_ACQUIRE:
                        begin
                            if (!bad_reg && in_use_bit)
                            begin
                                res_status = ST_OK;
                                res_index  = INDEX_W'(addr_reg);
                                res_count  = REF_W'(cnt_inc);
                                cnt_we     = 1'b1;
                                cnt_wdata  = {auto_cur, cnt_inc};
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (!bad_reg && in_use_bit)
                            begin
                                res_status = ST_OK;
                                res_index  = INDEX_W'(addr_reg);
                                cnt_we     = 1'b1;
                                if ((cnt_dec == '0) && auto_cur)
                                begin
                                    res_freed      = 1'b1;
                                    map_cmd.update = 1'b1;
                                    cnt_wdata      = '0;
                                end
                                else
                                begin
                                    res_count = REF_W'(cnt_dec);
                                    cnt_wdata = {auto_cur, cnt_dec};
                                end
                            end
                        end
                        default: res_status = ST_BAD;
                    endcase
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        if (exec_go)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_in;
            ar_reg   <= ar_in;
            bad_reg  <= bad_in;
            bit_reg  <= h_addr[BIT_AW-1:0];
            addr_reg <= h_addr;
        end
        if (exec_go)
        begin
            status_reg <= res_status;
            index_reg  <= res_index;
            count_reg  <= res_count;
            freed_reg  <= res_freed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op_in != OP_ALLOC))
            cnt_rd_reg <= cnt_mem[h_addr];
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, freed_reg, count_reg, index_reg};

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted word did not enter execute");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> m_tvalid)
        else $error("execute did not present a result");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[24:0] == 25'd0))
        else $error("error result carries nonzero fields");

    a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |-> ((m_tuser == ST_OK) && (m_tdata[23:8] == 16'd0)))
        else $error("freed slot reported with nonzero count or error");

endmodule
